// File: rtl/b2da_pkg.sv
// Package for the binary to decimal ASCII converter.
// Shared constants and the control struct of the BCD cell chain; no dependencies.
`default_nettype none

package b2da_pkg;

  localparam int unsigned BinW    = 32;
  localparam int unsigned NumDig  = 10;
  localparam int unsigned DigW    = 4;
  localparam int unsigned CharW   = 8;
  localparam int unsigned BitCntW = $clog2(BinW);
  localparam int unsigned RemW    = $clog2(NumDig + 1);

  localparam logic [BitCntW-1:0] LastBit   = BitCntW'(BinW - 1);
  localparam logic [RemW-1:0]    RemFull   = RemW'(NumDig);
  localparam logic [RemW-1:0]    RemOne    = RemW'(1);

  localparam logic [CharW-1:0]   CharZero  = 8'd48;
  localparam logic [CharW-1:0]   CharLf    = 8'd10;
  localparam logic [CharW-1:0]   CharCr    = 8'd13;

  // Control for every cell of the chain, same cycle.
  typedef struct packed {
    logic clear;       // load zero
    logic shift_bit;   // double-dabble step: adjust, shift one bit up
    logic shift_digit; // move each digit one cell up
  } chain_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/b2da_cell.sv
// One BCD digit cell of the conversion chain.
// Depends on b2da_pkg.
`default_nettype none

module b2da_cell import b2da_pkg::*; (
  input  wire logic              clk,
  input  wire chain_ctrl_t       ctrl,
  input  wire logic              carry_in,
  input  wire logic [DigW-1:0]   digit_in,
  output logic                   carry_out,
  output logic      [DigW-1:0]   digit
);

  logic [DigW-1:0] digit_r;
  logic [DigW-1:0] digit_nxt;
  logic [DigW-1:0] adj;

  // add 3 when >= 5 so the shift carries into the next decade
  assign adj       = (digit_r >= DigW'(5)) ? digit_r + DigW'(3) : digit_r;
  assign carry_out = adj[DigW-1];
  assign digit     = digit_r;

  always_comb begin
    priority if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.shift_bit) begin
      digit_nxt = {adj[DigW-2:0], carry_in};
    end else if (ctrl.shift_digit) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/b2da_chain.sv
// Row of BCD cells; bits enter at the low cell, digits leave from the high cell.
// Depends on b2da_pkg and b2da_cell.
`default_nettype none

module b2da_chain import b2da_pkg::*; (
  input  wire logic            clk,
  input  wire chain_ctrl_t     ctrl,
  input  wire logic            bit_in,
  output logic      [DigW-1:0] top_digit
);

  logic [NumDig-1:0]           carry;
  logic [NumDig-1:0][DigW-1:0] digits;

  for (genvar i = 0; i < NumDig; i++) begin : g_cell
    logic            cin;
    logic [DigW-1:0] din;
    if (i == 0) begin : g_low
      assign cin = bit_in;
      assign din = '0;
    end else begin : g_mid
      assign cin = carry[i-1];
      assign din = digits[i-1];
    end
    b2da_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  (cin),
      .digit_in  (din),
      .carry_out (carry[i]),
      .digit     (digits[i])
    );
  end

  assign top_digit = digits[NumDig-1];

endmodule

`default_nettype wire

// File: rtl/binary_to_decimal_ascii_top.sv
// Binary to decimal ASCII converter, top level. Depends on b2da_pkg and b2da_chain.
//
// Takes one 32-bit unsigned value per input transaction and emits its decimal
// text as ASCII bytes, most significant digit first, leading zeros dropped
// (zero prints as "0"), followed by LF and then CR; out_last marks the CR.
// One value is handled at a time: in_ready is high only while idle. The value
// is fed MSB first into a row of ten BCD cells (double dabble). Leading zero
// digits are then shifted out of the top cell, one per cycle. Each digit, LF
// and CR go out through a single output register, one byte per cycle when
// out_ready is held high. Per value: the accept step, the conversion steps,
// then the ten digit positions (the skipped leading zeros, a step to leave
// the skip state, the printed digits), then LF and CR. A stalled out_ready
// holds the digit, LF and CR steps. The next value may be accepted while the
// CR still waits in the output register.
`default_nettype none

module binary_to_decimal_ascii_top import b2da_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [BinW-1:0]  in_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [CharW-1:0] out_char_code,
  output logic                  out_last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SKIP  = 3'd2;
  localparam logic [2:0] ST_DIGIT = 3'd3;
  localparam logic [2:0] ST_LF    = 3'd4;
  localparam logic [2:0] ST_CR    = 3'd5;

  logic [2:0]         state_r,  state_nxt;
  logic [BinW-1:0]    bin_r,    bin_nxt;
  logic [BitCntW-1:0] cnt_r,    cnt_nxt;
  logic [RemW-1:0]    rem_r,    rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CharW-1:0]   out_char_r,  out_char_nxt;
  logic               out_last_r,  out_last_nxt;

  logic               out_free;
  logic               load;
  logic               skip_go;
  logic [DigW-1:0]    top_digit;
  chain_ctrl_t        ctrl;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  // drop a leading zero, but always keep the units digit
  assign skip_go  = (top_digit == '0) && (rem_r != RemOne);

  b2da_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (bin_r[BinW-1]),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt         = state_r;
    bin_nxt           = bin_r;
    cnt_nxt           = cnt_r;
    rem_nxt           = rem_r;
    load              = 1'b0;
    out_char_nxt      = out_char_r;
    out_last_nxt      = out_last_r;
    ctrl.clear        = 1'b0;
    ctrl.shift_bit    = 1'b0;
    ctrl.shift_digit  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bin_nxt    = in_value;
          cnt_nxt    = '0;
          ctrl.clear = 1'b1;
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.shift_bit = 1'b1;
        bin_nxt        = {bin_r[BinW-2:0], 1'b0};
        cnt_nxt        = cnt_r + BitCntW'(1);
        if (cnt_r == LastBit) begin
          rem_nxt   = RemFull;
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (skip_go) begin
          ctrl.shift_digit = 1'b1;
          rem_nxt          = rem_r - RemW'(1);
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          load             = 1'b1;
          out_char_nxt     = CharZero | CharW'(top_digit);
          out_last_nxt     = 1'b0;
          ctrl.shift_digit = 1'b1;
          rem_nxt          = rem_r - RemW'(1);
          if (rem_r == RemOne) begin
            state_nxt = ST_LF;
          end
        end
      end
      ST_LF: begin
        if (out_free) begin
          load         = 1'b1;
          out_char_nxt = CharLf;
          out_last_nxt = 1'b0;
          state_nxt    = ST_CR;
        end
      end
      ST_CR: begin
        if (out_free) begin
          load         = 1'b1;
          out_char_nxt = CharCr;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// File: rtl/b2da_checker.sv
// Port-level checks for the binary to decimal ASCII converter, plus its bind.
// Depends on b2da_pkg and binary_to_decimal_ascii_top.
`default_nettype none

module b2da_checker import b2da_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CharW-1:0] out_char_code,
  input wire logic             out_last
);

  // last flag only on CR
  a_last_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_char_code == CharCr))
    else $error("last set on a byte other than CR");

  // CR always ends the run
  a_cr_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_code == CharCr) |-> out_last)
    else $error("CR without last");

  // one value at a time: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while converting");

  // stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char_code) && $stable(out_last)))
    else $error("output changed while stalled");

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (.*);

`default_nettype wire

// File: test/tb_binary_to_decimal_ascii_top.sv
// Testbench for binary_to_decimal_ascii_top: checks every printed byte against a predictor.
// Depends on b2da_pkg and the converter RTL; drives valid/ready with random bursts and stalls.
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii_top;
  import b2da_pkg::*;

  localparam int unsigned RandomValues = 260;
  localparam int unsigned IdleLimit    = 2000;  // cycles with no transaction on either side
  localparam int unsigned TailCycles   = 60;    // settle time after the last byte

  // One expected output byte.
  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } ascii_byte_t;

  // Receiver ready patterns; the receiver switches between them at random.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_RARE,
    READY_BLOCKED
  } ready_mode_e;

  // Holds the bytes still owed by the converter, oldest first.
  class ascii_scoreboard;
    ascii_byte_t expected_q[$];
    int unsigned errors = 0;

    // Expands an accepted value into its decimal text, then LF and CR.
    function void note_value(logic [BinW-1:0] value);
      logic [BinW-1:0] rest;
      logic [3:0]      digit_q[$];
      ascii_byte_t     b;
      rest = value;
      // least significant digit first, pushed to the front so MSB ends up first
      do begin
        digit_q.push_front(4'(rest % 10));
        rest = rest / 10;
      end while (rest != 0);
      foreach (digit_q[i]) begin
        b.code = CharZero + {4'd0, digit_q[i]};
        b.last = 1'b0;
        expected_q.push_back(b);
      end
      b.code = CharLf;
      b.last = 1'b0;
      expected_q.push_back(b);
      b.code = CharCr;
      b.last = 1'b1;
      expected_q.push_back(b);
    endfunction

    function void check_byte(logic [CharW-1:0] code, logic last);
      ascii_byte_t exp_b;
      if (expected_q.size() == 0) begin
        $error("unexpected byte: char_code %0d, last %0b", code, last);
        errors++;
        return;
      end
      exp_b = expected_q.pop_front();
      if (code !== exp_b.code) begin
        $error("char_code: expected %0d, actual %0d", exp_b.code, code);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("last: expected %0b, actual %0b", exp_b.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [BinW-1:0]  in_value;
  logic             out_valid;
  logic             out_ready;
  logic [CharW-1:0] out_char_code;
  logic             out_last;

  ascii_scoreboard sb;
  int unsigned     quiet_cycles;

  binary_to_decimal_ascii_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // 10^n, wide enough for 10^10.
  function automatic longint unsigned pow10(int unsigned n);
    longint unsigned p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  // Random value mix: full-range words (covers every bit), values of a chosen
  // digit count (so short numbers show up often), tiny values, and values that
  // sit right on a power-of-ten boundary where the digit count changes.
  function automatic logic [BinW-1:0] pick_value();
    int unsigned     kind;
    int unsigned     n;
    longint unsigned lo;
    longint unsigned hi;
    kind = $urandom_range(9, 0);
    if (kind < 4) return $urandom();
    if (kind < 8) begin
      n  = $urandom_range(10, 1);
      lo = (n == 1) ? 0 : pow10(n - 1);
      hi = pow10(n) - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      return BinW'(lo + longint'($urandom_range(32'(hi - lo), 0)));
    end
    if (kind == 8) return BinW'($urandom_range(20, 0));
    n = $urandom_range(9, 1);
    return BinW'(pow10(n) - 1 + $urandom_range(2, 0));
  endfunction

  // Presents one value and waits for its transaction. Valid is left high so a
  // burst continues without a bubble; idle_sender drops it.
  task automatic send_value(logic [BinW-1:0] value);
    @(negedge clk);
    in_valid = 1'b1;
    in_value = value;
    do @(posedge clk); while (!in_ready);
    sb.note_value(value);
  endtask

  task automatic idle_sender(int unsigned cycles);
    @(negedge clk);
    in_valid = 1'b0;
    in_value = $urandom();  // junk while not valid
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Sender holds off until every owed byte has come out.
  task automatic hold_until_drained();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: out_ready follows a pattern that changes mode at random,
  // including fully blocked stretches and stretches of steady ready.
  initial begin
    ready_mode_e mode;
    int unsigned seg_left;
    out_ready = 1'b0;
    mode      = READY_ALWAYS;
    seg_left  = 0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        mode     = ready_mode_e'($urandom_range(3, 0));
        seg_left = (mode == READY_BLOCKED) ? $urandom_range(30, 5) : $urandom_range(120, 20);
      end
      seg_left--;
      case (mode)
        READY_ALWAYS:  out_ready = 1'b1;
        READY_COIN:    out_ready = 1'($urandom_range(1, 0));
        READY_RARE:    out_ready = ($urandom_range(5, 0) == 0);
        READY_BLOCKED: out_ready = 1'b0;
      endcase
    end
  end

  // Output monitor: every byte transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_byte(out_char_code, out_last);
  end

  // Watchdog: ends the run if neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [BinW-1:0] directed_values[$];
    int unsigned     sent;
    int unsigned     burst;
    sb           = new();
    quiet_cycles = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero, single digits, several digit count boundaries, the largest
    // ten-digit values and the full 32-bit maximum, plus alternating bit patterns.
    directed_values = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1234567890,
      32'd999999999, 32'd1000000000, 32'd1000000001, 32'd4294967294,
      32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
      32'hAAAA_AAAA, 32'd100000, 32'd65535, 32'd4000000000, 32'd3000000005
    };
    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      if (i % 4 == 3) idle_sender($urandom_range(6, 1));
    end
    hold_until_drained();

    // Random part: bursts of back-to-back values with random gaps between them;
    // now and then the sender waits for the converter to empty completely.
    sent = 0;
    while (sent < RandomValues) begin
      burst = $urandom_range(8, 1);
      repeat (burst) begin
        if (sent < RandomValues) begin
          send_value(pick_value());
          sent++;
        end
      end
      if ($urandom_range(15, 0) == 0) begin
        hold_until_drained();
      end else if ($urandom_range(3, 0) != 0) begin
        idle_sender($urandom_range(25, 1));
      end
    end

    hold_until_drained();
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
